FILE: design/fpd_pkg.sv
// Shared constants and types for the fixed-point divider.
`default_nettype none

package fpd_pkg;

    localparam int DATA_W         = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int IN_TDATA_W     = 2 * DATA_W;

    typedef struct packed {
        logic neg;
        logic zero;
    } t_flags;

    typedef struct packed {
        logic out_valid;
        logic skid_valid;
    } t_obuf_status;

endpackage

`default_nettype wire

FILE: design/fpd_prep.sv
// Input cell: takes operand magnitudes, the result sign and the zero-divisor flag.
`default_nettype none

module fpd_prep #(
    parameter int FRAC_BITS = fpd_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_en,
    input  wire logic                                     i_valid,
    input  wire logic signed [fpd_pkg::DATA_W-1:0]        i_dividend,
    input  wire logic signed [fpd_pkg::DATA_W-1:0]        i_divisor,
    output logic                                          o_valid,
    output logic        [fpd_pkg::DATA_W+FRAC_BITS-1:0]   o_num,
    output logic        [fpd_pkg::DATA_W-1:0]             o_den,
    output fpd_pkg::t_flags                               o_flags
);
    import fpd_pkg::*;

    localparam int QW = DATA_W + FRAC_BITS;

    logic              r_valid;
    logic [QW-1:0]     r_num;
    logic [DATA_W-1:0] r_den;
    t_flags            r_flags;

    logic [DATA_W-1:0] n_mag_a;
    logic [DATA_W-1:0] n_mag_b;
    t_flags            n_flags;

    always_comb begin
        n_mag_a = i_dividend[DATA_W-1] ? DATA_W'(-i_dividend) : DATA_W'(i_dividend);
        n_mag_b = i_divisor[DATA_W-1]  ? DATA_W'(-i_divisor)  : DATA_W'(i_divisor);
        n_flags.neg  = i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        n_flags.zero = (i_divisor == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num   <= {n_mag_a, {FRAC_BITS{1'b0}}};
            r_den   <= n_mag_b;
            r_flags <= n_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_flags = r_flags;

endmodule

`default_nettype wire

FILE: design/fpd_cell.sv
// Restoring division cell: resolves one quotient bit and passes the work on.
`default_nettype none

module fpd_cell #(
    parameter int FRAC_BITS = fpd_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_en,
    input  wire logic                                     i_valid,
    input  wire logic [fpd_pkg::DATA_W+FRAC_BITS-1:0]     i_num,
    input  wire logic [fpd_pkg::DATA_W-1:0]               i_rem,
    input  wire logic [fpd_pkg::DATA_W+FRAC_BITS-1:0]     i_quo,
    input  wire logic [fpd_pkg::DATA_W-1:0]               i_den,
    input  wire fpd_pkg::t_flags                          i_flags,
    output logic                                          o_valid,
    output logic      [fpd_pkg::DATA_W+FRAC_BITS-1:0]     o_num,
    output logic      [fpd_pkg::DATA_W-1:0]               o_rem,
    output logic      [fpd_pkg::DATA_W+FRAC_BITS-1:0]     o_quo,
    output logic      [fpd_pkg::DATA_W-1:0]               o_den,
    output fpd_pkg::t_flags                               o_flags
);
    import fpd_pkg::*;

    localparam int QW = DATA_W + FRAC_BITS;

    logic              r_valid;
    logic [QW-1:0]     r_num;
    logic [DATA_W-1:0] r_rem;
    logic [QW-1:0]     r_quo;
    logic [DATA_W-1:0] r_den;
    t_flags            r_flags;

    logic [DATA_W-1:0] n_trial;
    logic [DATA_W:0]   n_diff;
    logic              n_bit;
    logic [DATA_W-1:0] n_rem;

    // For a nonzero divisor the remainder stays below the divisor, at most 2^31, so its top bit is always clear.
    always_comb begin
        n_trial = {i_rem[DATA_W-2:0], i_num[QW-1]};
        n_diff  = {1'b0, n_trial} - {1'b0, i_den};
        n_bit   = !n_diff[DATA_W];
        n_rem   = n_bit ? n_diff[DATA_W-1:0] : n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num   <= {i_num[QW-2:0], 1'b0};
            r_rem   <= n_rem;
            r_quo   <= {i_quo[QW-2:0], n_bit};
            r_den   <= i_den;
            r_flags <= i_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_num   = r_num;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_den   = r_den;
    assign o_flags = r_flags;

endmodule

`default_nettype wire

FILE: design/fpd_out.sv
// Output cell: sign, range check and the output register with its skid stage.
`default_nettype none

module fpd_out #(
    parameter int FRAC_BITS = fpd_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire logic                                     i_valid,
    input  wire logic [fpd_pkg::DATA_W+FRAC_BITS-1:0]     i_quo,
    input  wire fpd_pkg::t_flags                          i_flags,
    input  wire logic                                     i_ready,
    output logic                                          o_valid,
    output logic      [fpd_pkg::DATA_W-1:0]               o_quotient,
    output logic                                          o_error,
    output fpd_pkg::t_obuf_status                         o_status
);
    import fpd_pkg::*;

    localparam int QW = DATA_W + FRAC_BITS;

    logic              r_ov;
    logic [DATA_W-1:0] r_oq;
    logic              r_oe;
    logic              r_sv;
    logic [DATA_W-1:0] r_sq;
    logic              r_se;

    logic              n_ov;
    logic [DATA_W-1:0] n_oq;
    logic              n_oe;
    logic              n_sv;
    logic [DATA_W-1:0] n_sq;
    logic              n_se;

    logic              w_hi;
    logic              w_err;
    logic [DATA_W-1:0] w_quo;

    always_comb begin
        w_hi = |i_quo[QW-1:DATA_W];
        if (i_flags.neg) begin
            w_err = w_hi || (i_quo[DATA_W-1] && (|i_quo[DATA_W-2:0]));
        end else begin
            w_err = w_hi || i_quo[DATA_W-1];
        end
        w_err = w_err || i_flags.zero;
        if (w_err) begin
            w_quo = '0;
        end else if (i_flags.neg) begin
            w_quo = DATA_W'('0 - i_quo[DATA_W-1:0]);
        end else begin
            w_quo = i_quo[DATA_W-1:0];
        end
    end

    always_comb begin
        n_ov = r_ov;
        n_oq = r_oq;
        n_oe = r_oe;
        n_sv = r_sv;
        n_sq = r_sq;
        n_se = r_se;
        if (!r_ov || i_ready) begin
            if (r_sv) begin
                n_ov = 1'b1;
                n_oq = r_sq;
                n_oe = r_se;
                n_sv = 1'b0;
            end else begin
                n_ov = i_valid;
                n_oq = w_quo;
                n_oe = w_err;
            end
        end else if (i_valid && !r_sv) begin
            n_sv = 1'b1;
            n_sq = w_quo;
            n_se = w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_ov <= n_ov;
            r_sv <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oq <= n_oq;
        r_oe <= n_oe;
        r_sq <= n_sq;
        r_se <= n_se;
    end

    assign o_valid             = r_ov;
    assign o_quotient          = r_oq;
    assign o_error             = r_oe;
    assign o_status.out_valid  = r_ov;
    assign o_status.skid_valid = r_sv;

endmodule

`default_nettype wire

FILE: design/fixed_point_divide.sv
// Top level of the pipelined signed fixed-point divider.
// From input transaction to output, data passes one input cell,
// one division cell per quotient bit (32 + FRAC_BITS of them) and one output cell.
// Throughput is one transaction per cycle while the skid stage is empty; the cell chain sets the latency.
// A skid stage at the output lets a new input be taken while a result waits.
// Reset is synchronous and active low; it clears all valid bits, those of the output register and skid stage too.
`default_nettype none

module fixed_point_divide #(
    parameter int FRAC_BITS = fpd_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // Fields from bit 0 up: dividend [31:0], divisor [63:32].
    input  wire logic [fpd_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // Fields from bit 0 up: quotient [31:0].
    output logic      [fpd_pkg::DATA_W-1:0]         o_m_axis_tdata,
    // Fields from bit 0 up: error_flag [0].
    output logic                                    o_m_axis_tuser
);
    import fpd_pkg::*;

    localparam int QW = DATA_W + FRAC_BITS;

    logic              w_en;
    t_obuf_status      w_status;

    logic              w_valid [0:QW];
    logic [QW-1:0]     w_num   [0:QW];
    logic [DATA_W-1:0] w_rem   [0:QW];
    logic [QW-1:0]     w_quo   [0:QW];
    logic [DATA_W-1:0] w_den   [0:QW];
    t_flags            w_flags [0:QW];

    assign w_en            = !w_status.skid_valid;
    assign o_s_axis_tready = w_en;

    fpd_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_s_axis_tvalid),
        .i_dividend (i_s_axis_tdata[DATA_W-1:0]),
        .i_divisor  (i_s_axis_tdata[IN_TDATA_W-1:DATA_W]),
        .o_valid    (w_valid[0]),
        .o_num      (w_num[0]),
        .o_den      (w_den[0]),
        .o_flags    (w_flags[0])
    );

    assign w_rem[0] = '0;
    assign w_quo[0] = '0;

    for (genvar k = 0; k < QW; k++) begin : g_cell
        fpd_cell #(
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[k]),
            .i_num   (w_num[k]),
            .i_rem   (w_rem[k]),
            .i_quo   (w_quo[k]),
            .i_den   (w_den[k]),
            .i_flags (w_flags[k]),
            .o_valid (w_valid[k+1]),
            .o_num   (w_num[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_quo   (w_quo[k+1]),
            .o_den   (w_den[k+1]),
            .o_flags (w_flags[k+1])
        );
    end

    fpd_out #(
        .FRAC_BITS (FRAC_BITS)
    ) u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_valid[QW]),
        .i_quo      (w_quo[QW]),
        .i_flags    (w_flags[QW]),
        .i_ready    (i_m_axis_tready),
        .o_valid    (o_m_axis_tvalid),
        .o_quotient (o_m_axis_tdata),
        .o_error    (o_m_axis_tuser),
        .o_status   (w_status)
    );

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.skid_valid |-> w_status.out_valid)
        else $error("skid stage holds a result while the output register is empty");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("error result carries a nonzero quotient");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_axis_tvalid && o_s_axis_tready))
        else $error("output valid or stall survived reset");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready && !w_status.skid_valid && !w_valid[QW])
        |=> !w_status.skid_valid)
        else $error("skid stage filled without an incoming result");

endmodule

`default_nettype wire
